>>> rtl/core/polynomial_feature_expander_unit_defines.svh
// assertion macros shared by the polynomial feature expander rtl
// no dependencies; taken in by files that carry concurrent checks
`ifndef POLYNOMIAL_FEATURE_EXPANDER_UNIT_DEFINES_SVH
`define POLYNOMIAL_FEATURE_EXPANDER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PFE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define PFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/pfe_pkg.sv
// shared types and constants of the polynomial feature expander
// no dependencies
`default_nettype none

package pfe_pkg;

	localparam int MAX_VARIABLES_DEF = 5;
	localparam int SAMPLE_BITS_DEF   = 16;

	localparam int SAMPLE_PORT_BITS = 16;
	localparam int SAMPLE_FRAC      = 12;
	localparam int OUT_FRAC         = 36;
	localparam int VALUE_BITS       = 48;
	localparam int INDEX_BITS       = 6;
	localparam int LIN_SHIFT        = OUT_FRAC - SAMPLE_FRAC;
	localparam int QUAD_SHIFT       = OUT_FRAC - 2 * SAMPLE_FRAC;

	localparam int LEN_BITS       = 3;
	localparam int EN_BITS        = 4;
	localparam int CFG_DATA_BITS  = 4;
	localparam int CFG_INDEX_BITS = 1;
	localparam int NUM_GROUPS     = 4;

	localparam logic [CFG_INDEX_BITS-1:0] REG_VECTOR_LENGTH = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TERM_ENABLE   = 1'd1;

	localparam logic [LEN_BITS-1:0] VECTOR_LENGTH_RST = 3'd4;
	localparam logic [EN_BITS-1:0]  TERM_ENABLE_RST   = 4'hf;

	localparam logic [VALUE_BITS-1:0] TERM_ONE = VALUE_BITS'(1) << OUT_FRAC;

	typedef enum logic [1:0] {
		GRP_CONST  = 2'd0,
		GRP_LINEAR = 2'd1,
		GRP_QUAD   = 2'd2,
		GRP_CUBIC  = 2'd3
	} group_t;

	// travels alongside the store read, one per issued term
	typedef struct packed {
		logic                  valid;
		group_t                group;
		logic [INDEX_BITS-1:0] index;
		logic                  last;
	} term_tag_t;

endpackage

`default_nettype wire

>>> rtl/core/pfe_store.sv
// sample store: two copies of the vector, one write port, three registered reads
// depends on pfe_pkg for nothing but is compiled after it
`default_nettype none

module pfe_store #(
	parameter int MAX_VARIABLES = 5,
	parameter int SAMPLE_BITS   = 16,
	parameter int IW            = (MAX_VARIABLES > 1) ? $clog2(MAX_VARIABLES) : 1
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [IW-1:0]                 waddr,
	input  wire logic signed [SAMPLE_BITS-1:0] wdata,
	input  wire logic [IW-1:0]                 raddr_a,
	input  wire logic [IW-1:0]                 raddr_b,
	input  wire logic [IW-1:0]                 raddr_c,
	output logic signed [SAMPLE_BITS-1:0]      rdata_a,
	output logic signed [SAMPLE_BITS-1:0]      rdata_b,
	output logic signed [SAMPLE_BITS-1:0]      rdata_c
);

	logic signed [SAMPLE_BITS-1:0] mem_a [MAX_VARIABLES];
	logic signed [SAMPLE_BITS-1:0] mem_b [MAX_VARIABLES];

	// both copies take every sample; first copy serves two factors, second the third
	always_ff @(posedge clk) begin
		if (we) begin
			mem_a[waddr] <= wdata;
			mem_b[waddr] <= wdata;
		end
		rdata_a <= mem_a[raddr_a];
		rdata_b <= mem_a[raddr_b];
		rdata_c <= mem_b[raddr_c];
	end

endmodule

`default_nettype wire

>>> rtl/core/pfe_seq.sv
// vector loader and term sequencer: writes samples, walks the monomial index space
// depends on pfe_pkg and polynomial_feature_expander_unit_defines.svh
`default_nettype none
`include "polynomial_feature_expander_unit_defines.svh"

module pfe_seq #(
	parameter int MAX_VARIABLES = 5,
	parameter int IW            = (MAX_VARIABLES > 1) ? $clog2(MAX_VARIABLES) : 1
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [pfe_pkg::LEN_BITS-1:0]   vector_length,
	input  wire logic [pfe_pkg::EN_BITS-1:0]    term_enable,
	output logic                                store_we,
	output logic [IW-1:0]                       store_waddr,
	output logic [IW-1:0]                       raddr_a,
	output logic [IW-1:0]                       raddr_b,
	output logic [IW-1:0]                       raddr_c,
	output pfe_pkg::term_tag_t                  tag_s0
);

	localparam logic [pfe_pkg::LEN_BITS-1:0] MAX_LEN = pfe_pkg::LEN_BITS'(MAX_VARIABLES);

	logic [IW-1:0]                     load_q;
	logic [IW-1:0]                     last_idx_q;
	logic                              active_q;
	pfe_pkg::group_t                   group_q;
	logic [IW-1:0]                     i_q;
	logic [IW-1:0]                     j_q;
	logic [IW-1:0]                     k_q;
	logic [pfe_pkg::INDEX_BITS-1:0]    index_q;

	logic                              accept;
	logic [pfe_pkg::LEN_BITS-1:0]      len_eff;
	logic [pfe_pkg::LEN_BITS-1:0]      load_cnt;
	logic                              load_done;
	logic                              first_found;
	pfe_pkg::group_t                   first_grp;
	logic                              nxt_found;
	pfe_pkg::group_t                   nxt_grp;
	logic                              grp_end;
	logic                              tag_last;

	assign accept = start && !busy;
	assign busy   = active_q;

	always_comb begin
		if (vector_length == '0) begin
			len_eff = pfe_pkg::LEN_BITS'(1);
		end else if (vector_length > MAX_LEN) begin
			len_eff = MAX_LEN;
		end else begin
			len_eff = vector_length;
		end
	end

	assign load_cnt  = pfe_pkg::LEN_BITS'(load_q) + pfe_pkg::LEN_BITS'(1);
	assign load_done = load_cnt >= len_eff;

	// lowest enabled group overall, and lowest enabled group above the current one
	always_comb begin
		first_found = 1'b0;
		first_grp   = pfe_pkg::GRP_CONST;
		nxt_found   = 1'b0;
		nxt_grp     = pfe_pkg::GRP_CONST;
		for (int g = pfe_pkg::NUM_GROUPS - 1; g >= 0; g--) begin
			if (term_enable[g]) begin
				first_found = 1'b1;
				first_grp   = pfe_pkg::group_t'(g[1:0]);
				if (g > int'(group_q)) begin
					nxt_found = 1'b1;
					nxt_grp   = pfe_pkg::group_t'(g[1:0]);
				end
			end
		end
	end

	// within a group i <= j <= k, so i at the top means the group is done
	assign grp_end  = (group_q == pfe_pkg::GRP_CONST) || (i_q == last_idx_q);
	assign tag_last = grp_end && !nxt_found;

	assign store_we    = accept;
	assign store_waddr = load_q;
	assign raddr_a     = i_q;
	assign raddr_b     = j_q;
	assign raddr_c     = k_q;

	assign tag_s0.valid = active_q;
	assign tag_s0.group = group_q;
	assign tag_s0.index = index_q;
	assign tag_s0.last  = tag_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q     <= '0;
			last_idx_q <= '0;
			active_q   <= 1'b0;
			group_q    <= pfe_pkg::GRP_CONST;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			index_q    <= '0;
		end else if (accept) begin
			if (load_done) begin
				load_q     <= '0;
				last_idx_q <= load_q;
				active_q   <= first_found;
				group_q    <= first_grp;
				i_q        <= '0;
				j_q        <= '0;
				k_q        <= '0;
				index_q    <= '0;
			end else begin
				load_q <= load_q + IW'(1);
			end
		end else if (active_q) begin
			index_q <= index_q + pfe_pkg::INDEX_BITS'(1);
			if (grp_end) begin
				if (nxt_found) begin
					group_q <= nxt_grp;
					i_q     <= '0;
					j_q     <= '0;
					k_q     <= '0;
				end else begin
					active_q <= 1'b0;
				end
			end else begin
				unique case (group_q)
					pfe_pkg::GRP_CONST: begin
						i_q <= i_q;
					end
					pfe_pkg::GRP_LINEAR: begin
						i_q <= i_q + IW'(1);
					end
					pfe_pkg::GRP_QUAD: begin
						if (j_q == last_idx_q) begin
							i_q <= i_q + IW'(1);
							j_q <= i_q + IW'(1);
						end else begin
							j_q <= j_q + IW'(1);
						end
					end
					pfe_pkg::GRP_CUBIC: begin
						if (k_q == last_idx_q) begin
							if (j_q == last_idx_q) begin
								i_q <= i_q + IW'(1);
								j_q <= i_q + IW'(1);
								k_q <= i_q + IW'(1);
							end else begin
								j_q <= j_q + IW'(1);
								k_q <= j_q + IW'(1);
							end
						end else begin
							k_q <= k_q + IW'(1);
						end
					end
				endcase
			end
		end
	end

	`PFE_ASSERT_NOW(a_no_write_in_emit, clk, arst_n, active_q, !store_we, "store written during emission")
	`PFE_ASSERT_NEXT(a_index_steps, clk, arst_n, active_q && !tag_last, active_q && (index_q == $past(index_q) + pfe_pkg::INDEX_BITS'(1)), "term index did not advance")
	`PFE_ASSERT_NOW(a_cubic_order, clk, arst_n, active_q && (group_q == pfe_pkg::GRP_CUBIC), (i_q <= j_q) && (j_q <= k_q) && (k_q <= last_idx_q), "cubic indices out of order")
	`PFE_ASSERT_NEXT(a_last_stops, clk, arst_n, active_q && tag_last, !active_q, "emission ran past last term")

endmodule

`default_nettype wire

>>> rtl/core/pfe_dp.sv
// product datapath: quadratic product, cubic product, group select, output register
// depends on pfe_pkg and polynomial_feature_expander_unit_defines.svh
`default_nettype none
`include "polynomial_feature_expander_unit_defines.svh"

module pfe_dp #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire pfe_pkg::term_tag_t                  tag_s0,
	input  wire logic signed [SAMPLE_BITS-1:0]       za,
	input  wire logic signed [SAMPLE_BITS-1:0]       zb,
	input  wire logic signed [SAMPLE_BITS-1:0]       zc,
	output logic                                     term_valid,
	output logic signed [pfe_pkg::VALUE_BITS-1:0]    term_value,
	output logic [pfe_pkg::INDEX_BITS-1:0]           term_index,
	output logic                                     last_term
);

	localparam int VW = pfe_pkg::VALUE_BITS;
	localparam int PW = 2 * SAMPLE_BITS;
	localparam int CW = 3 * SAMPLE_BITS;

	pfe_pkg::term_tag_t              tag_s1;
	pfe_pkg::term_tag_t              tag_s2;
	logic signed [PW-1:0]            prod_ab_s2;
	logic signed [SAMPLE_BITS-1:0]   za_s2;
	logic signed [SAMPLE_BITS-1:0]   zc_s2;
	logic signed [CW-1:0]            cube_full;
	logic signed [VW-1:0]            cube_value;
	logic signed [VW-1:0]            lin_value;
	logic signed [VW-1:0]            quad_value;
	logic signed [VW-1:0]            sel_value;
	logic                            term_valid_q;
	logic signed [VW-1:0]            term_value_q;
	logic [pfe_pkg::INDEX_BITS-1:0]  term_index_q;
	logic                            last_term_q;

	// tag lines up with the registered store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= tag_s0;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_ab_s2 <= za * zb;
		za_s2      <= za;
		zc_s2      <= zc;
	end

	assign cube_full = prod_ab_s2 * zc_s2;

	// keep the low value bits, the value wraps for wide samples
	generate
		if (CW >= VW) begin : g_cube_trunc
			assign cube_value = cube_full[VW-1:0];
		end else begin : g_cube_ext
			assign cube_value = {{(VW - CW){cube_full[CW-1]}}, cube_full};
		end
	endgenerate

	assign lin_value  = VW'(za_s2) <<< pfe_pkg::LIN_SHIFT;
	assign quad_value = VW'(prod_ab_s2) <<< pfe_pkg::QUAD_SHIFT;

	always_comb begin
		case (tag_s2.group)
			pfe_pkg::GRP_CONST:  sel_value = pfe_pkg::TERM_ONE;
			pfe_pkg::GRP_LINEAR: sel_value = lin_value;
			pfe_pkg::GRP_QUAD:   sel_value = quad_value;
			default:             sel_value = cube_value;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_valid_q <= 1'b0;
		end else begin
			term_valid_q <= tag_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		term_value_q <= sel_value;
		term_index_q <= tag_s2.index;
		last_term_q  <= tag_s2.last;
	end

	assign term_valid = term_valid_q;
	assign term_value = term_value_q;
	assign term_index = term_index_q;
	assign last_term  = last_term_q;

	`PFE_ASSERT_NEXT(a_dp_flow, clk, arst_n, tag_s2.valid, term_valid, "term lost in datapath")

endmodule

`default_nettype wire

>>> rtl/core/polynomial_feature_expander_unit.sv
// Degree-3 polynomial feature expander. A sample is taken on each start while busy
// is low; after the last sample of a vector busy stays high while terms are issued
// (up to 56), the sequencer issuing one store read per cycle. The first term reaches
// the outputs through the store read, product and output registers, and terms follow
// every cycle. The receiver cannot stall. Reset clears the counters and sets
// vector_length 4 and term_enable 15; the sample store is not cleared.
// depends on pfe_pkg, pfe_store, pfe_seq, pfe_dp
`default_nettype none

module polynomial_feature_expander_unit #(
	parameter int MAX_VARIABLES = pfe_pkg::MAX_VARIABLES_DEF,
	parameter int SAMPLE_BITS   = pfe_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    start,
	output logic                                         busy,
	input  wire logic signed [pfe_pkg::SAMPLE_PORT_BITS-1:0] sample_value,
	input  wire logic                                    cfg_we,
	input  wire logic [pfe_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
	input  wire logic [pfe_pkg::CFG_DATA_BITS-1:0]       cfg_data,
	output logic                                         term_valid,
	output logic signed [pfe_pkg::VALUE_BITS-1:0]        term_value,
	output logic [pfe_pkg::INDEX_BITS-1:0]               term_index,
	output logic                                         last_term
);

	localparam int IW = (MAX_VARIABLES > 1) ? $clog2(MAX_VARIABLES) : 1;

	logic [pfe_pkg::LEN_BITS-1:0]   vector_length_q;
	logic [pfe_pkg::EN_BITS-1:0]    term_enable_q;
	logic signed [SAMPLE_BITS-1:0]  sample_ext;
	logic                           store_we;
	logic [IW-1:0]                  store_waddr;
	logic [IW-1:0]                  raddr_a;
	logic [IW-1:0]                  raddr_b;
	logic [IW-1:0]                  raddr_c;
	logic signed [SAMPLE_BITS-1:0]  rdata_a;
	logic signed [SAMPLE_BITS-1:0]  rdata_b;
	logic signed [SAMPLE_BITS-1:0]  rdata_c;
	pfe_pkg::term_tag_t             tag_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vector_length_q <= pfe_pkg::VECTOR_LENGTH_RST;
			term_enable_q   <= pfe_pkg::TERM_ENABLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pfe_pkg::REG_VECTOR_LENGTH: vector_length_q <= cfg_data[pfe_pkg::LEN_BITS-1:0];
				pfe_pkg::REG_TERM_ENABLE:   term_enable_q   <= cfg_data[pfe_pkg::EN_BITS-1:0];
				default: begin
					term_enable_q <= term_enable_q;
				end
			endcase
		end
	end

	// low sample bits are two's complement; a wider sample zero-fills above the port
	generate
		if (SAMPLE_BITS <= pfe_pkg::SAMPLE_PORT_BITS) begin : g_smp_trunc
			assign sample_ext = sample_value[SAMPLE_BITS-1:0];
		end else begin : g_smp_ext
			assign sample_ext = {{(SAMPLE_BITS - pfe_pkg::SAMPLE_PORT_BITS){1'b0}},
				sample_value};
		end
	endgenerate

	pfe_seq #(
		.MAX_VARIABLES(MAX_VARIABLES),
		.IW(IW)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.vector_length(vector_length_q),
		.term_enable  (term_enable_q),
		.store_we     (store_we),
		.store_waddr  (store_waddr),
		.raddr_a      (raddr_a),
		.raddr_b      (raddr_b),
		.raddr_c      (raddr_c),
		.tag_s0       (tag_s0)
	);

	pfe_store #(
		.MAX_VARIABLES(MAX_VARIABLES),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.IW           (IW)
	) u_store (
		.clk    (clk),
		.we     (store_we),
		.waddr  (store_waddr),
		.wdata  (sample_ext),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.raddr_c(raddr_c),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b),
		.rdata_c(rdata_c)
	);

	pfe_dp #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_s0    (tag_s0),
		.za        (rdata_a),
		.zb        (rdata_b),
		.zc        (rdata_c),
		.term_valid(term_valid),
		.term_value(term_value),
		.term_index(term_index),
		.last_term (last_term)
	);

endmodule

`default_nettype wire
